// ----- src/bfha_pkg.sv -----
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  // Heap geometry
  localparam int MAX_HEAP_BYTES  = 16384;
  localparam int MIN_HEAP_BYTES  = 4096;
  localparam int MIN_SPLIT_BYTES = 32;
  localparam int FREE_LIST_DEPTH = 512;
  localparam int HEADER_BYTES    = 8;
  localparam int HDR_WORDS       = MAX_HEAP_BYTES / 4;

  // Field widths
  localparam int OFF_W  = 14;
  localparam int SIZE_W = 15;
  localparam int NEED_W = 17;

  // Derived index widths
  localparam int FL_AW  = $clog2(FREE_LIST_DEPTH);
  localparam int CNT_W  = FL_AW + 1;
  localparam int HDR_AW = $clog2(HDR_WORDS);
  localparam int CLR_W  = HDR_AW + 1;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_FREE  = 2'd1,
    TAG_ALLOC = 2'd2
  } tag_e;

  typedef struct packed {
    tag_e              tag;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SCAN,
    OP_RD_HDR,
    OP_CHK_HDR,
    OP_RD_PREV,
    OP_RD_NEXT,
    OP_CAP_NEXT,
    OP_A_TAKE,
    OP_A_SPLIT1,
    OP_A_SPLIT2,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_DEC_COUNT,
    OP_F_BOTH,
    OP_F_PREV,
    OP_F_NEXT,
    OP_CLR_HDR,
    OP_CLR_NEXT,
    OP_F_NONE_INIT,
    OP_F_INSERT
  } dp_op_e;

  // Controller to datapath
  typedef struct packed {
    dp_op_e  op;
    logic    load;
    logic    rsp_load;
    status_e rsp_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic up_done;
    logic dn_done;
    logic is_free;
    logic found;
    logic whole;
    logic bad_off;
    logic tag_alloc;
    logic prev_adj;
    logic next_adj;
    logic list_full;
  } stat_t;

endpackage

// ----- src/bfha_if.sv -----
// ----------------------------------------------------------------------------
// bfha request / response interfaces
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bfha_req_if import bfha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] request_bytes;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, action, request_bytes, free_offset, input ready);
  modport sink   (input valid, action, request_bytes, free_offset, output ready);
endinterface

interface bfha_rsp_if import bfha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [OFF_W-1:0]  block_offset;
  logic [SIZE_W-1:0] chunk_bytes;

  modport source (output valid, status, block_offset, chunk_bytes, input ready);
  modport sink   (input valid, status, block_offset, chunk_bytes, output ready);
endinterface

// ----- src/bfha_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfha_ctrl
// Sequencer: steps the datapath through clear, search, split/remove,
// coalesce and insert, and owns the handshakes.
// ----------------------------------------------------------------------------
module bfha_ctrl import bfha_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  logic  cfg_we_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_FRD   = 5'd2;
  localparam logic [4:0] S_FCHK  = 5'd3;
  localparam logic [4:0] S_SCAN  = 5'd4;
  localparam logic [4:0] S_ADEC  = 5'd5;
  localparam logic [4:0] S_ASPL2 = 5'd6;
  localparam logic [4:0] S_SHUP  = 5'd7;
  localparam logic [4:0] S_DECN  = 5'd8;
  localparam logic [4:0] S_FRDP  = 5'd9;
  localparam logic [4:0] S_FRDN  = 5'd10;
  localparam logic [4:0] S_FCAP  = 5'd11;
  localparam logic [4:0] S_FDEC  = 5'd12;
  localparam logic [4:0] S_FW2   = 5'd13;
  localparam logic [4:0] S_FW3   = 5'd14;
  localparam logic [4:0] S_SHDN  = 5'd15;
  localparam logic [4:0] S_FINS  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_q, state_d;
  status_e    st_q, st_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // Next state and datapath command
  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.op       = OP_NONE;
    cmd_o.load     = accept;
    cmd_o.rsp_load = 1'b0;
    cmd_o.rsp_status = st_q;

    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          state_d = stat_i.is_free ? S_FRD : S_SCAN;
          // is_free is the stored action; use the live field via load path
        end
      end
      S_FRD: begin
        cmd_o.op = OP_RD_HDR;
        state_d  = S_FCHK;
      end
      S_FCHK: begin
        cmd_o.op = OP_CHK_HDR;
        if (stat_i.bad_off || !stat_i.tag_alloc) begin
          st_d    = ST_BADFREE;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_done) state_d = stat_i.is_free ? S_FRDP : S_ADEC;
      end
      S_ADEC: begin
        if (!stat_i.found) begin
          st_d    = ST_NOFIT;
          state_d = S_DONE;
        end else if (stat_i.whole) begin
          cmd_o.op = OP_A_TAKE;
          state_d  = S_SHUP;
        end else begin
          cmd_o.op = OP_A_SPLIT1;
          state_d  = S_ASPL2;
        end
      end
      S_ASPL2: begin
        cmd_o.op = OP_A_SPLIT2;
        state_d  = S_DONE;
      end
      S_SHUP: begin
        cmd_o.op = OP_SHIFT_UP;
        if (stat_i.up_done) state_d = S_DECN;
      end
      S_DECN: begin
        cmd_o.op = OP_DEC_COUNT;
        state_d  = S_DONE;
      end
      S_FRDP: begin
        cmd_o.op = OP_RD_PREV;
        state_d  = S_FRDN;
      end
      S_FRDN: begin
        cmd_o.op = OP_RD_NEXT;
        state_d  = S_FCAP;
      end
      S_FCAP: begin
        cmd_o.op = OP_CAP_NEXT;
        state_d  = S_FDEC;
      end
      S_FDEC: begin
        if (stat_i.prev_adj && stat_i.next_adj) begin
          cmd_o.op = OP_F_BOTH;
          state_d  = S_FW2;
        end else if (stat_i.prev_adj) begin
          cmd_o.op = OP_F_PREV;
          state_d  = S_FW2;
        end else if (stat_i.next_adj) begin
          cmd_o.op = OP_F_NEXT;
          state_d  = S_FW3;
        end else if (stat_i.list_full) begin
          st_d    = ST_BADFREE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_F_NONE_INIT;
          state_d  = S_SHDN;
        end
      end
      S_FW2: begin
        cmd_o.op = OP_CLR_HDR;
        state_d  = stat_i.next_adj ? S_FW3 : S_DONE;
      end
      S_FW3: begin
        cmd_o.op = OP_CLR_NEXT;
        state_d  = stat_i.prev_adj ? S_SHUP : S_DONE;
      end
      S_SHDN: begin
        cmd_o.op = OP_SHIFT_DOWN;
        if (stat_i.dn_done) state_d = S_FINS;
      end
      S_FINS: begin
        cmd_o.op = OP_F_INSERT;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // Result goes to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    // Heap re-forms on any register write
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/bfha_dp.sv -----
// ----------------------------------------------------------------------------
// bfha_dp
// Datapath: header store, sorted free list, scan pipeline, list shifter
// and result register.
// ----------------------------------------------------------------------------
module bfha_dp import bfha_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              action_i,
  input  logic [SIZE_W-1:0] request_bytes_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  output logic [1:0]        status_o,
  output logic [OFF_W-1:0]  block_offset_o,
  output logic [SIZE_W-1:0] chunk_bytes_o
);

  // Memories
  logic [OFF_W-1:0] fl_mem [FREE_LIST_DEPTH];
  hdr_t             hd_mem [HDR_WORDS];
  logic [OFF_W-1:0] fl_rd_q;
  hdr_t             hd_rd_q;

  logic              fl_we, hd_we;
  logic [FL_AW-1:0]  fl_raddr, fl_waddr;
  logic [OFF_W-1:0]  fl_wdata;
  logic [HDR_AW-1:0] hd_raddr, hd_waddr;
  hdr_t              hd_wdata;

  // State
  logic [SIZE_W-1:0] heap_q, heap_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic              action_q, action_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [OFF_W-1:0]  fo_q, fo_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              found_q, found_d;
  logic [FL_AW-1:0]  bidx_q, bidx_d;
  logic [SIZE_W-1:0] bsize_q, bsize_d;
  logic [OFF_W-1:0]  boff_q, boff_d;
  logic [CNT_W-1:0]  ia_q, ia_d;
  logic              v1_q, v1_d, v2_q, v2_d;
  logic [CNT_W-1:0]  idx1_q, idx1_d;
  logic [FL_AW-1:0]  idx2_q, idx2_d;
  logic [OFF_W-1:0]  off2_q, off2_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [OFF_W-1:0]  po_q, po_d, no_q, no_d;
  logic              hasp_q, hasp_d, hasn_q, hasn_d;
  logic [SIZE_W-1:0] ps_q, ps_d, ns_q, ns_d;
  logic [1:0]        rst_q, rst_d;
  logic [OFF_W-1:0]  roff_q, roff_d;
  logic [SIZE_W-1:0] rchunk_q, rchunk_d;

  // Derived values
  logic [OFF_W-1:0]  hdr_off, split_off;
  logic [NEED_W:0]   split_lim;
  logic              whole, fits, better, prev_adj, next_adj;
  logic [15:0]       cfg_sum, cfg_rnd;
  logic [NEED_W-1:0] req_sum, req_need;

  assign hdr_off   = fo_q - OFF_W'(HEADER_BYTES);
  assign split_off = boff_q + need_q[OFF_W-1:0];
  assign split_lim = {1'b0, need_q} + (NEED_W+1)'(MIN_SPLIT_BYTES);
  assign whole     = ((NEED_W+1)'(bsize_q) <= split_lim);
  assign fits      = (NEED_W'(hd_rd_q.size) >= need_q);
  assign better    = !found_q || (hd_rd_q.size < bsize_q);
  assign prev_adj  = hasp_q && ((16'(po_q) + 16'(ps_q)) == 16'(hdr_off));
  assign next_adj  = hasn_q && ((16'(hdr_off) + 16'(size_q)) == 16'(no_q));
  assign cfg_sum   = 16'(cfg_wdata_i) + 16'd3;
  assign cfg_rnd   = {cfg_sum[15:2], 2'b00};
  assign req_sum   = NEED_W'(request_bytes_i) + NEED_W'(3);
  assign req_need  = {req_sum[NEED_W-1:2], 2'b00} + NEED_W'(HEADER_BYTES);

  // Status to the controller
  always_comb begin
    stat_o.clear_done = clr_q[CLR_W-1];
    stat_o.scan_done  = (ia_q >= count_q) && !v1_q && !v2_q;
    stat_o.up_done    = (ia_q >= count_q) && !v1_q;
    stat_o.dn_done    = (ia_q <= p_q) && !v1_q;
    stat_o.is_free    = cmd_i.load ? action_i : action_q;
    stat_o.found      = found_q;
    stat_o.whole      = whole;
    stat_o.bad_off    = (fo_q < OFF_W'(HEADER_BYTES)) || (SIZE_W'(fo_q) >= heap_q) ||
                        (fo_q[1:0] != 2'b00);
    stat_o.tag_alloc  = (hd_rd_q.tag == TAG_ALLOC);
    stat_o.prev_adj   = prev_adj;
    stat_o.next_adj   = next_adj;
    stat_o.list_full  = (count_q >= CNT_W'(FREE_LIST_DEPTH));
  end

  // Operation decode
  always_comb begin
    heap_d = heap_q;  count_d = count_q;  clr_d = clr_q;
    action_d = action_q;  need_d = need_q;  fo_d = fo_q;  size_d = size_q;
    found_d = found_q;  bidx_d = bidx_q;  bsize_d = bsize_q;  boff_d = boff_q;
    ia_d = ia_q;  v1_d = 1'b0;  v2_d = 1'b0;  idx1_d = idx1_q;  idx2_d = idx2_q;
    off2_d = off2_q;  p_d = p_q;  po_d = po_q;  no_d = no_q;
    hasp_d = hasp_q;  hasn_d = hasn_q;  ps_d = ps_q;  ns_d = ns_q;
    rst_d = rst_q;  roff_d = roff_q;  rchunk_d = rchunk_q;

    fl_we    = 1'b0;
    fl_raddr = ia_q[FL_AW-1:0];
    fl_waddr = idx1_q[FL_AW-1:0];
    fl_wdata = fl_rd_q;
    hd_we    = 1'b0;
    hd_raddr = fl_rd_q[OFF_W-1:2];
    hd_waddr = boff_q[OFF_W-1:2];
    hd_wdata = '0;

    // Capture a new request and reset the search state
    if (cmd_i.load) begin
      action_d = action_i;
      need_d   = req_need;
      fo_d     = free_offset_i;
      found_d  = 1'b0;
      ia_d     = '0;
      p_d      = '0;
      hasp_d   = 1'b0;
      hasn_d   = 1'b0;
    end

    case (cmd_i.op)
      OP_CLEAR: begin
        if (!clr_q[CLR_W-1]) begin
          hd_we    = 1'b1;
          hd_waddr = clr_q[HDR_AW-1:0];
          if (clr_q == '0) begin
            hd_wdata.tag  = TAG_FREE;
            hd_wdata.size = heap_q;
            fl_we    = 1'b1;
            fl_waddr = '0;
            fl_wdata = '0;
          end
          clr_d = clr_q + CLR_W'(1);
        end
      end
      OP_SCAN: begin
        // stage 0: list read
        if (ia_q < count_q) begin
          v1_d   = 1'b1;
          idx1_d = ia_q;
          ia_d   = ia_q + CNT_W'(1);
        end
        // stage 1: offset back, header read issued
        v2_d   = v1_q;
        idx2_d = idx1_q[FL_AW-1:0];
        off2_d = fl_rd_q;
        if (v1_q && action_q) begin
          if (fl_rd_q < hdr_off) begin
            p_d    = idx1_q + CNT_W'(1);
            po_d   = fl_rd_q;
            hasp_d = 1'b1;
          end else if (!hasn_q) begin
            no_d   = fl_rd_q;
            hasn_d = 1'b1;
          end
        end
        // stage 2: best-fit compare
        if (v2_q && !action_q && fits && better) begin
          found_d = 1'b1;
          bidx_d  = idx2_q;
          bsize_d = hd_rd_q.size;
          boff_d  = off2_q;
        end
      end
      OP_RD_HDR:   hd_raddr = hdr_off[OFF_W-1:2];
      OP_CHK_HDR:  size_d = hd_rd_q.size;
      OP_RD_PREV:  hd_raddr = po_q[OFF_W-1:2];
      OP_RD_NEXT: begin
        hd_raddr = no_q[OFF_W-1:2];
        ps_d     = hd_rd_q.size;
      end
      OP_CAP_NEXT: ns_d = hd_rd_q.size;
      OP_A_TAKE: begin
        hd_we         = 1'b1;
        hd_wdata.tag  = TAG_ALLOC;
        hd_wdata.size = bsize_q;
        ia_d          = CNT_W'(bidx_q) + CNT_W'(1);
      end
      OP_A_SPLIT1: begin
        hd_we         = 1'b1;
        hd_wdata.tag  = TAG_ALLOC;
        hd_wdata.size = need_q[SIZE_W-1:0];
      end
      OP_A_SPLIT2: begin
        hd_we         = 1'b1;
        hd_waddr      = split_off[OFF_W-1:2];
        hd_wdata.tag  = TAG_FREE;
        hd_wdata.size = bsize_q - need_q[SIZE_W-1:0];
        fl_we         = 1'b1;
        fl_waddr      = bidx_q;
        fl_wdata      = split_off;
      end
      OP_SHIFT_UP: begin
        // fl[k] <= fl[k+1]
        if (ia_q < count_q) begin
          v1_d   = 1'b1;
          idx1_d = ia_q - CNT_W'(1);
          ia_d   = ia_q + CNT_W'(1);
        end
        fl_we = v1_q;
      end
      OP_SHIFT_DOWN: begin
        // fl[k+1] <= fl[k]
        if (ia_q > p_q) begin
          fl_raddr = FL_AW'(ia_q - CNT_W'(1));
          v1_d     = 1'b1;
          idx1_d   = ia_q;
          ia_d     = ia_q - CNT_W'(1);
        end
        fl_we = v1_q;
      end
      OP_DEC_COUNT: count_d = count_q - CNT_W'(1);
      OP_F_BOTH: begin
        hd_we         = 1'b1;
        hd_waddr      = po_q[OFF_W-1:2];
        hd_wdata.tag  = TAG_FREE;
        hd_wdata.size = ps_q + size_q + ns_q;
        ia_d          = p_q + CNT_W'(1);
      end
      OP_F_PREV: begin
        hd_we         = 1'b1;
        hd_waddr      = po_q[OFF_W-1:2];
        hd_wdata.tag  = TAG_FREE;
        hd_wdata.size = ps_q + size_q;
      end
      OP_F_NEXT: begin
        hd_we         = 1'b1;
        hd_waddr      = hdr_off[OFF_W-1:2];
        hd_wdata.tag  = TAG_FREE;
        hd_wdata.size = size_q + ns_q;
        fl_we         = 1'b1;
        fl_waddr      = p_q[FL_AW-1:0];
        fl_wdata      = hdr_off;
      end
      OP_CLR_HDR: begin
        hd_we    = 1'b1;
        hd_waddr = hdr_off[OFF_W-1:2];
      end
      OP_CLR_NEXT: begin
        hd_we    = 1'b1;
        hd_waddr = no_q[OFF_W-1:2];
      end
      OP_F_NONE_INIT: ia_d = count_q;
      OP_F_INSERT: begin
        fl_we         = 1'b1;
        fl_waddr      = p_q[FL_AW-1:0];
        fl_wdata      = hdr_off;
        hd_we         = 1'b1;
        hd_waddr      = hdr_off[OFF_W-1:2];
        hd_wdata.tag  = TAG_FREE;
        hd_wdata.size = size_q;
        count_d       = count_q + CNT_W'(1);
      end
      default: ;
    endcase

    // Result register
    if (cmd_i.rsp_load) begin
      rst_d    = cmd_i.rsp_status;
      roff_d   = '0;
      rchunk_d = '0;
      if (cmd_i.rsp_status == ST_OK && !action_q) begin
        roff_d   = boff_q + OFF_W'(HEADER_BYTES);
        rchunk_d = whole ? bsize_q : need_q[SIZE_W-1:0];
      end
    end

    // Heap size write: round up to a word, clamp, restart clearing pass
    if (cfg_we_i) begin
      if (cfg_rnd < 16'(MIN_HEAP_BYTES))      heap_d = SIZE_W'(MIN_HEAP_BYTES);
      else if (cfg_rnd > 16'(MAX_HEAP_BYTES)) heap_d = SIZE_W'(MAX_HEAP_BYTES);
      else                                    heap_d = cfg_rnd[SIZE_W-1:0];
      clr_d   = '0;
      count_d = CNT_W'(1);
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    fl_rd_q <= fl_mem[fl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) hd_mem[hd_waddr] <= hd_wdata;
    hd_rd_q <= hd_mem[hd_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q  <= SIZE_W'(MIN_HEAP_BYTES);
      count_q <= CNT_W'(1);
      clr_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ia_q    <= '0;
      found_q <= 1'b0;
      hasp_q  <= 1'b0;
      hasn_q  <= 1'b0;
      rst_q   <= ST_OK;
    end else begin
      heap_q  <= heap_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      ia_q    <= ia_d;
      found_q <= found_d;
      hasp_q  <= hasp_d;
      hasn_q  <= hasn_d;
      rst_q   <= rst_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    need_q   <= need_d;
    fo_q     <= fo_d;
    size_q   <= size_d;
    bidx_q   <= bidx_d;
    bsize_q  <= bsize_d;
    boff_q   <= boff_d;
    idx1_q   <= idx1_d;
    idx2_q   <= idx2_d;
    off2_q   <= off2_d;
    p_q      <= p_d;
    po_q     <= po_d;
    no_q     <= no_d;
    ps_q     <= ps_d;
    ns_q     <= ns_d;
    roff_q   <= roff_d;
    rchunk_q <= rchunk_d;
  end

  assign status_o       = rst_q;
  assign block_offset_o = roff_q;
  assign chunk_bytes_o  = rchunk_q;

endmodule

// ----- src/best_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator with split and coalescing over a byte heap.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction payload
//  ---------+-----+-------------------------------------------------
//  req_i    | in  | action, request_bytes, free_offset
//  rsp_o    | out | status, block_offset, chunk_bytes
//  cfg      | in  | cfg_we_i / cfg_wdata_i: heap_bytes, write only
//
//  One request at a time. Allocate: the whole free list is scanned, then
//  the best chunk is split or taken whole, or no fit is answered. Free:
//  the list is scanned, then one merge, a double merge or an insert
//  follows; a bad offset or tag answers with no scan. One entry per cycle.
//  After reset and each heap_bytes write a clearing pass sweeps
//  the header store; no request is taken during it. A result waits in the
//  output register while the next request runs.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator import bfha_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  bfha_req_if.sink          req_i,
  bfha_rsp_if.source        rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  bfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cfg_we_i    (cfg_we_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfha_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (req_i.action),
    .request_bytes_i (req_i.request_bytes),
    .free_offset_i   (req_i.free_offset),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_o        (rsp_o.status),
    .block_offset_o  (rsp_o.block_offset),
    .chunk_bytes_o   (rsp_o.chunk_bytes)
  );

`ifndef SYNTHESIS
  // One request in flight: ready drops after each accepted transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // A heap size write starts the clearing pass
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request taken during clearing pass");

  // Failed requests and frees carry no block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |->
      (rsp_o.block_offset == '0) && (rsp_o.chunk_bytes == '0))
    else $error("failed result carries a block");
`endif

endmodule
